// ===== rtl/multipath_link_health_monitor_macros.svh =====
// Assertion macros for the link health monitor.
`ifndef MULTIPATH_LINK_HEALTH_MONITOR_MACROS_SVH
`define MULTIPATH_LINK_HEALTH_MONITOR_MACROS_SVH
`ifndef SYNTHESIS
`define MLHM_ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define MLHM_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define MLHM_ASSERT_IMPL(label, clk, rst_n, a, c)
`define MLHM_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

// ===== rtl/mlhm_pkg.sv =====
// ----------------------------------------------------------------------------
// mlhm_pkg
// Shared constants, codes and command/status types of the link health monitor.
// ----------------------------------------------------------------------------
`default_nettype none
package mlhm_pkg;
    localparam int NumPaths   = 4;
    localparam int PathW      = 2;
    localparam int LossWindow = 16;
    localparam int SlotW      = 4;
    localparam int TallyW     = 5;

    localparam logic [2:0] KIND_TX     = 3'd0;
    localparam logic [2:0] KIND_RX     = 3'd1;
    localparam logic [2:0] KIND_LOSS   = 3'd2;
    localparam logic [2:0] KIND_TICK   = 3'd3;
    localparam logic [2:0] KIND_SELECT = 3'd4;

    localparam logic [1:0] ST_UNKNOWN  = 2'd0;
    localparam logic [1:0] ST_ACTIVE   = 2'd1;
    localparam logic [1:0] ST_DEGRADED = 2'd2;
    localparam logic [1:0] ST_DOWN     = 2'd3;

    localparam logic [2:0] REG_PATHS     = 3'd0;
    localparam logic [2:0] REG_DEFAULT   = 3'd1;
    localparam logic [2:0] REG_MULTIPATH = 3'd2;
    localparam logic [2:0] REG_HEARTBEAT = 3'd3;
    localparam logic [2:0] REG_RECONNECT = 3'd4;

    // controller -> datapath
    typedef struct packed {
        logic             load;     // capture input item
        logic             upd;      // apply per-path update (tx/rx/loss)
        logic             rtt;      // apply rtt update stage
        logic             visit;    // tick/select visit of path r_idx
        logic [PathW-1:0] idx;      // path being visited
        logic             sel_init; // initialize select search
        logic             finish;   // form result into output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [2:0] kind;
        logic       ok;
        logic [2:0] n_used;
    } t_sts;
endpackage
`default_nettype wire

// ===== rtl/mlhm_datapath.sv =====
// ----------------------------------------------------------------------------
// mlhm_datapath
// Per-path health records, event update arithmetic and the result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "multipath_link_health_monitor_macros.svh"
module mlhm_datapath
    import mlhm_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_cmd          i_cmd,
    output t_sts               o_sts,
    input  wire logic          i_cfg_we,
    input  wire logic [2:0]    i_cfg_idx,
    input  wire logic [31:0]   i_cfg_data,
    input  wire logic [2:0]    i_kind,
    input  wire logic [3:0]    i_path_index,
    input  wire logic [39:0]   i_rtt_sample_ns,
    input  wire logic [47:0]   i_now_ms,
    output logic [1:0]         o_path_status,
    output logic [4:0]         o_window_losses,
    output logic [39:0]        o_rtt_average_ns,
    output logic [39:0]        o_rtt_jitter_ns,
    output logic [39:0]        o_rtt_low_ns,
    output logic [39:0]        o_rtt_high_ns,
    output logic [31:0]        o_sent_total,
    output logic [31:0]        o_received_total,
    output logic [31:0]        o_lost_total,
    output logic [1:0]         o_chosen_path,
    output logic               o_states_changed
);
    logic [2:0]  r_paths;
    logic [1:0]  r_default;
    logic        r_multi;
    logic [31:0] r_hb;
    logic [31:0] r_rc;

    logic [1:0]            r_state [NumPaths];
    logic [LossWindow-1:0] r_bits  [NumPaths];
    logic [SlotW-1:0]      r_slot  [NumPaths];
    logic [TallyW-1:0]     r_tally [NumPaths];
    logic [39:0]           r_avg   [NumPaths];
    logic [39:0]           r_jit   [NumPaths];
    logic [39:0]           r_min   [NumPaths];
    logic [39:0]           r_max   [NumPaths];
    logic [31:0]           r_tx    [NumPaths];
    logic [31:0]           r_rx    [NumPaths];
    logic [31:0]           r_drop  [NumPaths];
    logic [47:0]           r_seen  [NumPaths];

    logic [2:0]  r_kind;
    logic [3:0]  r_pidx;
    logic [39:0] r_rtt;
    logic [47:0] r_now;
    logic        r_changed;
    logic [PathW-1:0]  r_best;
    logic [TallyW:0]   r_best_tally;

    logic              ok;
    logic [PathW-1:0]  p;
    logic [2:0]        n_used;
    assign ok     = (r_pidx < 4'(NumPaths));
    assign p      = r_pidx[PathW-1:0];
    assign n_used = (r_paths > 3'(NumPaths)) ? 3'(NumPaths) : r_paths;
    assign o_sts  = '{kind: r_kind, ok: ok, n_used: n_used};

    // receive arithmetic, from pre-update values of path p
    logic [39:0] prev, diff, new_avg, new_jit;
    logic [42:0] avg_sum, jit_sum;
    logic        cur_bit;
    logic [TallyW-1:0] new_tally;
    assign prev    = r_avg[p];
    assign diff    = (r_rtt > prev) ? r_rtt - prev : prev - r_rtt;
    assign avg_sum = {3'b0, prev} * 43'd7 + {3'b0, r_rtt};
    assign new_avg = (prev != '0) ? avg_sum[42:3] : r_rtt;
    assign jit_sum = {3'b0, r_jit[p]} * 43'd7 + {3'b0, diff};
    assign new_jit = (r_jit[p] != '0) ? jit_sum[42:3] : diff;
    assign cur_bit = (r_kind == KIND_LOSS);
    assign new_tally = r_tally[p] - TallyW'(r_bits[p][r_slot[p]]) + TallyW'(cur_bit);

    // tick / select of visited path
    logic [47:0] quiet;
    logic [33:0] hb3;
    logic        to_deg, to_down;
    assign quiet   = r_now - r_seen[i_cmd.idx];
    assign hb3     = {2'b0, r_hb} * 34'd3;
    assign to_deg  = (r_state[i_cmd.idx] == ST_ACTIVE) && (quiet > {14'b0, hb3});
    assign to_down = ((r_state[i_cmd.idx] == ST_DEGRADED) || to_deg)
                     && (quiet > {16'b0, r_rc});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_paths   <= 3'd1;
            r_default <= '0;
            r_multi   <= 1'b0;
            r_hb      <= 32'd1000;
            r_rc      <= 32'd5000;
            for (int i = 0; i < NumPaths; i++) begin
                r_state[i] <= ST_UNKNOWN;
                r_bits[i]  <= '0;
                r_slot[i]  <= '0;
                r_tally[i] <= '0;
                r_avg[i]   <= '0;
                r_jit[i]   <= '0;
                r_min[i]   <= '0;
                r_max[i]   <= '0;
                r_tx[i]    <= '0;
                r_rx[i]    <= '0;
                r_drop[i]  <= '0;
                r_seen[i]  <= '0;
            end
            r_kind    <= '0;
            r_changed <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_PATHS:     r_paths   <= i_cfg_data[2:0];
                    REG_DEFAULT:   r_default <= i_cfg_data[1:0];
                    REG_MULTIPATH: r_multi   <= i_cfg_data[0];
                    REG_HEARTBEAT: r_hb      <= i_cfg_data;
                    REG_RECONNECT: r_rc      <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                r_kind    <= i_kind;
                r_pidx    <= i_path_index;
                r_rtt     <= i_rtt_sample_ns;
                r_now     <= i_now_ms;
                r_changed <= 1'b0;
            end
            if (i_cmd.upd) begin
                unique case (r_kind)
                    KIND_TX: r_tx[p] <= r_tx[p] + 32'd1;
                    KIND_RX, KIND_LOSS: begin
                        r_bits[p][r_slot[p]] <= cur_bit;
                        r_slot[p]  <= r_slot[p] + SlotW'(1);
                        r_tally[p] <= new_tally;
                        if (cur_bit) begin
                            r_drop[p] <= r_drop[p] + 32'd1;
                            if (new_tally > TallyW'(LossWindow / 2))
                                r_state[p] <= ST_DOWN;
                            else if (10 * int'(new_tally) > 3 * LossWindow)
                                r_state[p] <= ST_DEGRADED;
                        end else begin
                            r_rx[p]    <= r_rx[p] + 32'd1;
                            r_seen[p]  <= r_now;
                            r_state[p] <= ST_ACTIVE;
                        end
                    end
                    default: ;
                endcase
            end
            if (i_cmd.rtt && r_rtt != '0) begin
                if (r_min[p] == '0 || r_rtt < r_min[p]) r_min[p] <= r_rtt;
                if (r_rtt > r_max[p]) r_max[p] <= r_rtt;
                r_avg[p] <= new_avg;
                if (prev != '0) r_jit[p] <= new_jit;
            end
            if (i_cmd.visit && r_kind == KIND_TICK) begin
                if (to_down) begin
                    r_state[i_cmd.idx] <= ST_DOWN;
                    r_changed <= 1'b1;
                end else if (to_deg) begin
                    r_state[i_cmd.idx] <= ST_DEGRADED;
                    r_changed <= 1'b1;
                end
            end
        end
    end

    // select search
    always_ff @(posedge i_clk) begin
        if (i_cmd.sel_init) begin
            r_best       <= r_default;
            r_best_tally <= {1'b0, r_tally[r_default]};
        end else if (i_cmd.visit && r_kind == KIND_SELECT) begin
            if (r_state[i_cmd.idx] == ST_ACTIVE
                && {1'b0, r_tally[i_cmd.idx]} < r_best_tally) begin
                r_best       <= i_cmd.idx;
                r_best_tally <= {1'b0, r_tally[i_cmd.idx]};
            end
        end
    end

    logic [1:0] chosen;
    always_comb begin
        chosen = '0;
        if (r_kind == KIND_SELECT && r_paths != '0)
            chosen = r_multi ? r_best : r_default;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_path_status    <= ok ? r_state[p] : '0;
            o_window_losses  <= ok ? r_tally[p] : '0;
            o_rtt_average_ns <= ok ? r_avg[p]   : '0;
            o_rtt_jitter_ns  <= ok ? r_jit[p]   : '0;
            o_rtt_low_ns     <= ok ? r_min[p]   : '0;
            o_rtt_high_ns    <= ok ? r_max[p]   : '0;
            o_sent_total     <= ok ? r_tx[p]    : '0;
            o_received_total <= ok ? r_rx[p]    : '0;
            o_lost_total     <= ok ? r_drop[p]  : '0;
            o_chosen_path    <= chosen;
            o_states_changed <= (r_kind == KIND_TICK) && r_changed;
        end
    end

    logic rx_upd;
    assign rx_upd = i_cmd.upd && r_kind == KIND_RX && ok;

    `MLHM_ASSERT_IMPL(a_tally_bound, i_clk, i_rst_n, 1'b1, r_tally[0] <= TallyW'(LossWindow))
    `MLHM_ASSERT_NEXT(a_rx_active, i_clk, i_rst_n, rx_upd, r_state[$past(p)] == ST_ACTIVE)
    `MLHM_ASSERT_IMPL(a_upd_ok, i_clk, i_rst_n, i_cmd.upd, ok)
endmodule
`default_nettype wire

// ===== rtl/mlhm_ctrl.sv =====
// ----------------------------------------------------------------------------
// mlhm_ctrl
// Sequencer: load, per-path update or path visit loop, result, handshake.
// ----------------------------------------------------------------------------
`default_nettype none
`include "multipath_link_health_monitor_macros.svh"
module mlhm_ctrl
    import mlhm_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    output logic      o_valid,
    input  wire logic i_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_UPD  = 3'd2;
    localparam logic [2:0] S_RTT  = 3'd3;
    localparam logic [2:0] S_VIS  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0]       r_state, n_state;
    logic [2:0]       r_idx, n_idx;
    logic             r_ovalid, n_ovalid;

    // result register frees when taken; accept while it waits is fine since
    // finish only happens once it is empty or is being taken
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ovalid;

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_ovalid = r_ovalid && !i_ready;
        o_cmd    = '0;
        o_cmd.idx = r_idx[PathW-1:0];
        unique case (r_state)
            S_IDLE: if (i_valid) begin
                o_cmd.load = 1'b1;
                n_state    = S_DEC;
            end
            S_DEC: begin
                n_idx = '0;
                priority if (i_sts.kind == KIND_TICK || i_sts.kind == KIND_SELECT) begin
                    o_cmd.sel_init = 1'b1;
                    n_state = S_VIS;
                end else if (i_sts.ok && (i_sts.kind == KIND_TX || i_sts.kind == KIND_RX
                             || i_sts.kind == KIND_LOSS)) begin
                    n_state = (i_sts.kind == KIND_RX) ? S_RTT : S_UPD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_RTT: begin
                o_cmd.rtt = 1'b1;
                n_state   = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = S_FIN;
            end
            S_VIS: begin
                if (r_idx < i_sts.n_used) begin
                    o_cmd.visit = 1'b1;
                    n_idx = r_idx + 3'd1;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: if (!r_ovalid || i_ready) begin
                o_cmd.finish = 1'b1;
                n_ovalid     = 1'b1;
                n_state      = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_ovalid <= n_ovalid;
        end
    end

    `MLHM_ASSERT_NEXT(a_fin_valid, i_clk, i_rst_n, o_cmd.finish, r_ovalid)
    `MLHM_ASSERT_IMPL(a_no_overwrite, i_clk, i_rst_n, o_cmd.finish, !r_ovalid || i_ready)
    `MLHM_ASSERT_IMPL(a_visit_range, i_clk, i_rst_n, o_cmd.visit, r_idx < 3'(NumPaths))
endmodule
`default_nettype wire

// ===== rtl/multipath_link_health_monitor.sv =====
// Steps between decode and result: update (transmit/loss), rtt and update
//   (receive), visits (tick/select), none for others or out-of-range paths.
// Throughput: one item at a time; the next item is taken the cycle after the
//   result is formed, while that result may still wait in its output register.
// Reset (synchronous, active low) clears every path record and loads register
//   defaults: one path in use, default path 0, single path, 1000/5000 ms.
// ----------------------------------------------------------------------------
// multipath_link_health_monitor
// Per-path health tracking of several network paths with best-path select.
// ----------------------------------------------------------------------------
`default_nettype none
module multipath_link_health_monitor
    import mlhm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write port
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    // event input channel
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [2:0]  i_kind,
    input  wire logic [3:0]  i_path_index,
    input  wire logic [39:0] i_rtt_sample_ns,
    input  wire logic [47:0] i_now_ms,
    // result channel
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_path_status,
    output logic [4:0]       o_window_losses,
    output logic [39:0]      o_rtt_average_ns,
    output logic [39:0]      o_rtt_jitter_ns,
    output logic [39:0]      o_rtt_low_ns,
    output logic [39:0]      o_rtt_high_ns,
    output logic [31:0]      o_sent_total,
    output logic [31:0]      o_received_total,
    output logic [31:0]      o_lost_total,
    output logic [1:0]       o_chosen_path,
    output logic             o_states_changed
);
    t_cmd cmd;
    t_sts sts;

    // Sequencer: decode the event, then run the update steps or walk the
    // paths one per cycle for tick and select, then hold the result.
    mlhm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Datapath: path records, receive smoothing, loss window, timeouts.
    mlhm_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_kind           (i_kind),
        .i_path_index     (i_path_index),
        .i_rtt_sample_ns  (i_rtt_sample_ns),
        .i_now_ms         (i_now_ms),
        .o_path_status    (o_path_status),
        .o_window_losses  (o_window_losses),
        .o_rtt_average_ns (o_rtt_average_ns),
        .o_rtt_jitter_ns  (o_rtt_jitter_ns),
        .o_rtt_low_ns     (o_rtt_low_ns),
        .o_rtt_high_ns    (o_rtt_high_ns),
        .o_sent_total     (o_sent_total),
        .o_received_total (o_received_total),
        .o_lost_total     (o_lost_total),
        .o_chosen_path    (o_chosen_path),
        .o_states_changed (o_states_changed)
    );
endmodule
`default_nettype wire
